@@ hdl/scs_pkg.sv @@
// Shared types, codes and constants of the spatial coalescent step engine.
package scs_pkg;

   // Default lattice depth; memories and counters size themselves from it.
   localparam int LATTICE_CELLS_DEF = 4096;

   // Fixed field widths of the request, response and register interfaces.
   localparam int CELL_W    = 12;
   localparam int SIZE_W    = 13;
   localparam int DRAW_W    = 16;
   localparam int RATE_W    = 17;
   localparam int PROT_W    = 16;
   localparam int DISP_W    = 14;
   localparam int SPECIES_W = 13;
   localparam int TIME_W    = 48;
   localparam int CSR_DW    = 17;

   // Time step is floor(DIV_DIVIDEND / lineages); the quotient needs QUO_W bits.
   localparam int DIV_DIVIDEND = 131072;
   localparam int QUO_W        = 18;
   localparam int DIV_STEPS    = QUO_W;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [SPECIES_W-1:0] SPECIES_RESET = SPECIES_W'(1);

   // Request action codes.
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_EVENT = 1'b1;

   typedef enum logic [2:0] {
      OUT_LOADED     = 3'd0,
      OUT_REFUSED    = 3'd1,
      OUT_SPECIATED  = 3'd2,
      OUT_MERGED     = 3'd3,
      OUT_MOVED      = 3'd4,
      OUT_REJECTED   = 3'd5,
      OUT_BAD_VICTIM = 3'd6,
      OUT_FINISHED   = 3'd7
   } outcome_type;

   typedef enum logic [1:0] {
      REG_SPEC_RATE  = 2'd0,
      REG_PROTRACT   = 2'd1,
      REG_MASK       = 2'd2,
      REG_LATTICE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [RATE_W-1:0] speciation_rate;
      logic [PROT_W-1:0] protraction_time;
      logic              mask_enabled;
      logic [SIZE_W-1:0] lattice_size;
   } cfg_type;

   typedef struct packed {
      logic                     action;
      logic [CELL_W-1:0]        cell_req;
      logic                     cell_live;
      logic                     cell_sampled;
      logic [CELL_W-1:0]        victim;
      logic [DRAW_W-1:0]        spec_draw;
      logic signed [DISP_W-1:0] displacement;
   } req_type;

   typedef struct packed {
      outcome_type          outcome;
      logic [CELL_W-1:0]    written_cell;
      logic [CELL_W-1:0]    written_value;
      logic                 value_is_species;
      logic [SIZE_W-1:0]    remaining;
      logic                 done_res;
      logic [CELL_W-1:0]    final_cell;
      logic [SPECIES_W-1:0] final_species;
   } rsp_type;

endpackage

@@ hdl/scs_req_if.sv @@
// Request channel: cell loads and event attempts.
interface scs_req_if;
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic [scs_pkg::CELL_W-1:0]        cell_req;
   logic                              cell_live;
   logic                              cell_sampled;
   logic [scs_pkg::CELL_W-1:0]        victim;
   logic [scs_pkg::DRAW_W-1:0]        spec_draw;
   logic signed [scs_pkg::DISP_W-1:0] displacement;

   modport source (output valid, action, cell_req, cell_live, cell_sampled, victim,
                   spec_draw, displacement, input ready);
   modport sink (input valid, action, cell_req, cell_live, cell_sampled, victim,
                 spec_draw, displacement, output ready);
endinterface

@@ hdl/scs_rsp_if.sv @@
// Response channel: one result per request.
interface scs_rsp_if;
   logic                          valid;
   logic                          ready;
   scs_pkg::outcome_type          outcome;
   logic [scs_pkg::CELL_W-1:0]    written_cell;
   logic [scs_pkg::CELL_W-1:0]    written_value;
   logic                          value_is_species;
   logic [scs_pkg::SIZE_W-1:0]    remaining;
   logic                          done_res;
   logic [scs_pkg::CELL_W-1:0]    final_cell;
   logic [scs_pkg::SPECIES_W-1:0] final_species;

   modport source (output valid, outcome, written_cell, written_value, value_is_species,
                   remaining, done_res, final_cell, final_species, input ready);
   modport sink (input valid, outcome, written_cell, written_value, value_is_species,
                 remaining, done_res, final_cell, final_species, output ready);
endinterface

@@ hdl/scs_csr_if.sv @@
// Register write channel.
interface scs_csr_if;
   logic                         valid;
   logic                         ready;
   scs_pkg::csr_index_type       index;
   logic [scs_pkg::CSR_DW-1:0]   wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

@@ hdl/scs_recip.sv @@
// Restoring divider giving floor(DIV_DIVIDEND / divisor), one quotient bit per cycle.
module scs_recip #(
   parameter int CNTW = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [CNTW-1:0]             divisor,
   output logic                        done,
   output logic [scs_pkg::QUO_W-1:0]   quotient
);

   localparam int SW = $clog2(scs_pkg::DIV_STEPS + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [SW-1:0]             step_ff, step_in;
   logic [CNTW-1:0]           rem_ff, rem_in;
   logic [scs_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [CNTW-1:0]           div_ff, div_in;
   logic [CNTW:0]             cand;
   logic                      ge;

   // One shift-and-subtract step; the dividend shifts out as quotient bits shift in.
   always_comb begin
      cand    = {rem_ff, quo_ff[scs_pkg::QUO_W-1]};
      ge      = cand >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = scs_pkg::QUO_W'(scs_pkg::DIV_DIVIDEND);
         div_in  = divisor;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         rem_in  = ge ? CNTW'(cand - {1'b0, div_ff}) : CNTW'(cand);
         quo_in  = {quo_ff[scs_pkg::QUO_W-2:0], ge};
         if (step_ff == SW'(scs_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/scs_engine.sv @@
// Lineage engine: cell and lineage memories with the read-modify-write sequencer.
module scs_engine #(
   parameter int LATTICE_CELLS = scs_pkg::LATTICE_CELLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  scs_pkg::cfg_type cfg,
   input  logic             req_fire,
   input  scs_pkg::req_type req,
   output logic             req_ready,
   input  logic             res_free,
   output logic             res_push,
   output scs_pkg::rsp_type res
);

   localparam int CW   = $clog2(LATTICE_CELLS);
   localparam int CNTW = $clog2(LATTICE_CELLS + 1);
   localparam int UW   = CNTW > scs_pkg::SIZE_W ? CNTW : scs_pkg::SIZE_W;
   localparam int TW   = (CW > scs_pkg::DISP_W ? CW : scs_pkg::DISP_W) + 2;
   localparam int MW   = TW > UW ? TW : UW;

   typedef enum logic [12:0] {
      ST_CLEAR  = 13'b0000000000001,
      ST_IDLE   = 13'b0000000000010,
      ST_LOAD   = 13'b0000000000100,
      ST_VIC    = 13'b0000000001000,
      ST_CELL   = 13'b0000000010000,
      ST_MOVE   = 13'b0000000100000,
      ST_PAR    = 13'b0000001000000,
      ST_LAST   = 13'b0000010000000,
      ST_UNLINK = 13'b0000100000000,
      ST_DIV    = 13'b0001000000000,
      ST_FIN    = 13'b0010000000000,
      ST_FIN2   = 13'b0100000000000,
      ST_OUT    = 13'b1000000000000
   } state_type;

   // Lineage memory holds {position, origin}; cell memory holds habitat and {valid, slot}.
   logic [2*CW-1:0] lin_mem [LATTICE_CELLS];
   logic            cell_hab_mem [LATTICE_CELLS];
   logic [CW:0]     cell_link_mem [LATTICE_CELLS];

   logic [2*CW-1:0] lin_rd_ff;
   logic            hab_rd_ff;
   logic [CW:0]     link_rd_ff;

   logic [CW-1:0]   lin_raddr, lin_waddr, cell_raddr, cell_waddr;
   logic [2*CW-1:0] lin_wdata;
   logic            lin_we, hab_we, link_we, hab_wd;
   logic [CW:0]     link_wd;

   state_type                       state_ff, state_in;
   logic [CNTW-1:0]                 cnt_ff, cnt_in;
   logic [scs_pkg::SPECIES_W-1:0]   spc_ff, spc_in;
   logic [scs_pkg::TIME_W-1:0]      time_ff, time_in;
   logic                            started_ff, started_in;
   logic [CW-1:0]                   clr_ff, clr_in;
   scs_pkg::req_type                req_ff, req_in;
   logic                            spec_ff, spec_in;
   logic [2*CW-1:0]                 vdat_ff, vdat_in;
   logic [CW-1:0]                   tgt_ff, tgt_in;
   scs_pkg::rsp_type                res_ff, res_in;

   logic [UW-1:0]                   in_use;
   logic                            time_ok, draw_ok, cell_ok, victim_ok, t_ok;
   logic signed [TW-1:0]            t_calc;
   logic [CW-1:0]                   here, victim_idx, last_idx;
   logic [scs_pkg::TIME_W:0]        time_sum;
   logic                            div_start, div_done;
   logic [scs_pkg::QUO_W-1:0]       div_quo;

   scs_recip #(.CNTW(CNTW)) u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Checks on the incoming request and on the victim's dispersal target.
   always_comb begin
      in_use     = (UW'(cfg.lattice_size) < UW'(LATTICE_CELLS)) ? UW'(cfg.lattice_size)
                                                                 : UW'(LATTICE_CELLS);
      time_ok    = time_ff >= scs_pkg::TIME_W'({cfg.protraction_time, 16'h0000});
      draw_ok    = scs_pkg::RATE_W'(req.spec_draw) < cfg.speciation_rate;
      cell_ok    = UW'(req.cell_req) < in_use;
      victim_ok  = UW'(req.victim) < UW'(cnt_ff);
      here       = vdat_ff[2*CW-1:CW];
      victim_idx = CW'(req_ff.victim);
      last_idx   = CW'(cnt_ff - 1'b1);
      t_calc     = $signed({{(TW-CW){1'b0}}, lin_rd_ff[2*CW-1:CW]})
                   + TW'(req_ff.displacement);
      t_ok       = !t_calc[TW-1] && (t_calc != '0)
                   && (MW'($unsigned(t_calc)) < MW'(in_use));
      time_sum   = (scs_pkg::TIME_W+1)'(time_ff) + (scs_pkg::TIME_W+1)'(div_quo);
   end

   // Sequencer: each state issues at most one read and one write per memory.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      spc_in     = spc_ff;
      time_in    = time_ff;
      started_in = started_ff;
      clr_in     = clr_ff;
      req_in     = req_ff;
      spec_in    = spec_ff;
      vdat_in    = vdat_ff;
      tgt_in     = tgt_ff;
      res_in     = res_ff;
      lin_raddr  = '0;
      cell_raddr = '0;
      lin_we     = 1'b0;
      lin_waddr  = '0;
      lin_wdata  = '0;
      cell_waddr = '0;
      hab_we     = 1'b0;
      link_we    = 1'b0;
      hab_wd     = 1'b0;
      link_wd    = '0;
      div_start  = 1'b0;
      res_push   = 1'b0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            hab_we     = 1'b1;
            link_we    = 1'b1;
            cell_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == CW'(LATTICE_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               req_in         = req;
               res_in         = '0;
               res_in.outcome = scs_pkg::OUT_REFUSED;
               if (req.action == scs_pkg::ACT_LOAD) begin
                  cell_raddr = CW'(req.cell_req);
                  state_in   = (!started_ff && cell_ok) ? ST_LOAD : ST_OUT;
               end else begin
                  started_in = 1'b1;
                  lin_raddr  = CW'(req.victim);
                  spec_in    = time_ok && draw_ok;
                  if (cnt_ff < CNTW'(2)) begin
                     res_in.outcome = scs_pkg::OUT_FINISHED;
                     state_in       = ST_FIN;
                  end else if (!victim_ok) begin
                     res_in.outcome = scs_pkg::OUT_BAD_VICTIM;
                     state_in       = ST_OUT;
                  end else begin
                     state_in = ST_VIC;
                  end
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_OUT;
            if (!link_rd_ff[CW]) begin
               res_in.outcome = scs_pkg::OUT_LOADED;
               cell_waddr     = CW'(req_ff.cell_req);
               hab_we         = 1'b1;
               hab_wd         = req_ff.cell_live;
               if (req_ff.cell_live && req_ff.cell_sampled
                   && (cnt_ff < CNTW'(LATTICE_CELLS))) begin
                  link_we   = 1'b1;
                  link_wd   = {1'b1, CW'(cnt_ff)};
                  lin_we    = 1'b1;
                  lin_waddr = CW'(cnt_ff);
                  lin_wdata = {CW'(req_ff.cell_req), CW'(req_ff.cell_req)};
                  cnt_in    = cnt_ff + 1'b1;
               end
            end
         end
         ST_VIC: begin
            vdat_in = lin_rd_ff;
            if (spec_ff) begin
               res_in.outcome          = scs_pkg::OUT_SPECIATED;
               res_in.written_cell     = scs_pkg::CELL_W'(lin_rd_ff[CW-1:0]);
               res_in.written_value    = scs_pkg::CELL_W'(spc_ff);
               res_in.value_is_species = 1'b1;
               spc_in                  = spc_ff + 1'b1;
               lin_raddr               = last_idx;
               state_in                = ST_LAST;
            end else if (!t_ok) begin
               res_in.outcome = scs_pkg::OUT_REJECTED;
               state_in       = ST_OUT;
            end else begin
               tgt_in     = CW'(t_calc);
               cell_raddr = CW'(t_calc);
               state_in   = ST_CELL;
            end
         end
         ST_CELL: begin
            if (cfg.mask_enabled && !hab_rd_ff) begin
               res_in.outcome = scs_pkg::OUT_REJECTED;
               state_in       = ST_OUT;
            end else if (tgt_ff == here) begin
               res_in.outcome = scs_pkg::OUT_MOVED;
               div_start      = 1'b1;
               state_in       = ST_DIV;
            end else if (link_rd_ff[CW]) begin
               res_in.outcome      = scs_pkg::OUT_MERGED;
               res_in.written_cell = scs_pkg::CELL_W'(vdat_ff[CW-1:0]);
               lin_raddr           = link_rd_ff[CW-1:0];
               state_in            = ST_PAR;
            end else begin
               res_in.outcome = scs_pkg::OUT_MOVED;
               link_we        = 1'b1;
               cell_waddr     = tgt_ff;
               link_wd        = {1'b1, victim_idx};
               lin_we         = 1'b1;
               lin_waddr      = victim_idx;
               lin_wdata      = {tgt_ff, vdat_ff[CW-1:0]};
               state_in       = ST_MOVE;
            end
         end
         ST_MOVE: begin
            // The vacated cell loses its lineage.
            link_we    = 1'b1;
            cell_waddr = here;
            link_wd    = '0;
            div_start  = 1'b1;
            state_in   = ST_DIV;
         end
         ST_PAR: begin
            res_in.written_value = scs_pkg::CELL_W'(lin_rd_ff[CW-1:0]);
            lin_raddr            = last_idx;
            state_in             = ST_LAST;
         end
         ST_LAST: begin
            // The last lineage takes over the victim's slot.
            link_we    = 1'b1;
            cell_waddr = lin_rd_ff[2*CW-1:CW];
            link_wd    = {1'b1, victim_idx};
            lin_we     = 1'b1;
            lin_waddr  = victim_idx;
            lin_wdata  = lin_rd_ff;
            cnt_in     = cnt_ff - 1'b1;
            state_in   = ST_UNLINK;
         end
         ST_UNLINK: begin
            // Written after the take-over so that a victim in the last slot ends unlinked.
            link_we    = 1'b1;
            cell_waddr = here;
            link_wd    = '0;
            div_start  = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               time_in  = time_sum[scs_pkg::TIME_W] ? scs_pkg::TIME_MAX
                                                    : time_sum[scs_pkg::TIME_W-1:0];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (cnt_ff == CNTW'(1)) begin
               lin_raddr = '0;
               state_in  = ST_FIN2;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_FIN2: begin
            res_in.done_res      = 1'b1;
            res_in.final_cell    = scs_pkg::CELL_W'(lin_rd_ff[CW-1:0]);
            res_in.final_species = spc_ff;
            state_in             = ST_OUT;
         end
         ST_OUT: begin
            if (res_free) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         spc_ff     <= scs_pkg::SPECIES_RESET;
         time_ff    <= '0;
         started_ff <= 1'b0;
         clr_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         spc_ff     <= spc_in;
         time_ff    <= time_in;
         started_ff <= started_in;
         clr_ff     <= clr_in;
      end
   end

   // Per-request working registers.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      spec_ff <= spec_in;
      vdat_ff <= vdat_in;
      tgt_ff  <= tgt_in;
      res_ff  <= res_in;
   end

   // Lineage memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (lin_we) begin
         lin_mem[lin_waddr] <= lin_wdata;
      end
      lin_rd_ff <= lin_mem[lin_raddr];
   end

   // Cell memory, with separate write enables for the habitat and link fields.
   always_ff @(posedge clock) begin
      if (hab_we) begin
         cell_hab_mem[cell_waddr] <= hab_wd;
      end
      if (link_we) begin
         cell_link_mem[cell_waddr] <= link_wd;
      end
      hab_rd_ff  <= cell_hab_mem[cell_raddr];
      link_rd_ff <= cell_link_mem[cell_raddr];
   end

   // The lineage count is reported as it stands when the result leaves.
   always_comb begin
      res           = res_ff;
      res.remaining = scs_pkg::SIZE_W'(cnt_ff);
   end

endmodule

@@ hdl/spatial_coalescent_step.sv @@
// Top level: register port, request intake and response output register.
//
// Backward-time lineage engine on a one-dimensional lattice. After reset the block sweeps
// its cell memory clear, one cell per cycle, and accepts no request until the sweep is
// done; register writes are taken throughout. An event that changes the state waits on
// the bit-serial divider that forms the 18-bit time step floor(131072 / remaining), after
// the dependent reads and write-backs of the lineage and cell memories, each of which
// has a registered read. A finished result waits in an output register, so a new request
// is taken while the previous response is held.
module spatial_coalescent_step #(
   parameter int LATTICE_CELLS = scs_pkg::LATTICE_CELLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   scs_req_if.sink     req_chan,
   scs_rsp_if.source   rsp_chan,
   scs_csr_if.sink     csr_chan
);

   scs_pkg::cfg_type cfg_ff, cfg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   scs_pkg::rsp_type rsp_data_ff, rsp_data_in;
   scs_pkg::req_type req;
   scs_pkg::rsp_type res;
   logic             req_ready, req_fire, res_free, res_push;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            scs_pkg::REG_SPEC_RATE: cfg_in.speciation_rate  = scs_pkg::RATE_W'(csr_chan.wdata);
            scs_pkg::REG_PROTRACT:  cfg_in.protraction_time = scs_pkg::PROT_W'(csr_chan.wdata);
            scs_pkg::REG_MASK:      cfg_in.mask_enabled     = csr_chan.wdata[0];
            scs_pkg::REG_LATTICE:   cfg_in.lattice_size     = scs_pkg::SIZE_W'(csr_chan.wdata);
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   // Request intake.
   always_comb begin
      req.action       = req_chan.action;
      req.cell_req     = req_chan.cell_req;
      req.cell_live    = req_chan.cell_live;
      req.cell_sampled = req_chan.cell_sampled;
      req.victim       = req_chan.victim;
      req.spec_draw    = req_chan.spec_draw;
      req.displacement = req_chan.displacement;
   end

   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;

   scs_engine #(.LATTICE_CELLS(LATTICE_CELLS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_fire  (req_fire),
      .req       (req),
      .req_ready (req_ready),
      .res_free  (res_free),
      .res_push  (res_push),
      .res       (res)
   );

   // Output register: refilled when empty or when its response is taken.
   always_comb begin
      res_free     = !rsp_valid_ff || rsp_chan.ready;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff                 <= 1'b0;
         cfg_ff.speciation_rate       <= '0;
         cfg_ff.protraction_time      <= '0;
         cfg_ff.mask_enabled          <= 1'b0;
         cfg_ff.lattice_size          <= scs_pkg::SIZE_W'(4096);
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.outcome          = rsp_data_ff.outcome;
   assign rsp_chan.written_cell     = rsp_data_ff.written_cell;
   assign rsp_chan.written_value    = rsp_data_ff.written_value;
   assign rsp_chan.value_is_species = rsp_data_ff.value_is_species;
   assign rsp_chan.remaining        = rsp_data_ff.remaining;
   assign rsp_chan.done_res         = rsp_data_ff.done_res;
   assign rsp_chan.final_cell       = rsp_data_ff.final_cell;
   assign rsp_chan.final_species    = rsp_data_ff.final_species;

endmodule
